### design/nfab_pkg.sv
// Package for the NFA byte matcher: field widths, request and label codes,
// and the packed layout of one NFA table entry.
// No dependencies; every other design file refers to it by scoped names.
package nfab_pkg;

  localparam int REQ_W       = 2;
  localparam int IDX_FIELD_W = 6;
  localparam int LABEL_W     = 9;
  localparam int BYTE_W      = 8;

  // request codes
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_START = 2'd1;
  localparam logic [REQ_W-1:0] REQ_BYTE  = 2'd2;

  // special labels
  localparam logic [LABEL_W-1:0] LABEL_EPSILON = 9'd256;
  localparam logic [LABEL_W-1:0] LABEL_ACCEPT  = 9'd257;

  // one successor link: present flag and entry index
  typedef struct packed {
    logic                   present;
    logic [IDX_FIELD_W-1:0] idx;
  } link_t;

  // one NFA table entry
  typedef struct packed {
    logic [LABEL_W-1:0] label;
    link_t              first;
    link_t              second;
  } tbl_entry_t;

endpackage

### design/nfab_ifs.sv
// Valid/ready channel interfaces of the NFA byte matcher: request items in,
// match status items out. Depends on nfab_pkg for field widths.

interface nfab_in_if;
  logic                              valid;
  logic                              ready;
  logic [nfab_pkg::REQ_W-1:0]        req_type;
  logic [nfab_pkg::IDX_FIELD_W-1:0]  entry_index;
  logic [nfab_pkg::LABEL_W-1:0]      entry_label;
  logic [nfab_pkg::IDX_FIELD_W-1:0]  first_next;
  logic                              first_present;
  logic [nfab_pkg::IDX_FIELD_W-1:0]  second_next;
  logic                              second_present;
  logic [nfab_pkg::BYTE_W-1:0]       data_byte;

  modport source (
    output valid, req_type, entry_index, entry_label, first_next, first_present,
           second_next, second_present, data_byte,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_index, entry_label, first_next, first_present,
           second_next, second_present, data_byte,
    output ready
  );
endinterface

interface nfab_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic any_active;

  modport source (output valid, matched, any_active, input ready);
  modport sink   (input valid, matched, any_active, output ready);
endinterface

### design/nfab_table.sv
// NFA table memory: one write port for load items, one read port whose
// data is registered. Depends on nfab_pkg for the entry layout.
module nfab_table #(
  parameter int NUM_STATES = 64
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(NUM_STATES)-1:0]  wr_addr,
  input  nfab_pkg::tbl_entry_t           wr_data,
  input  logic [$clog2(NUM_STATES)-1:0]  rd_addr,
  output nfab_pkg::tbl_entry_t           rd_data
);

  nfab_pkg::tbl_entry_t mem [NUM_STATES];
  nfab_pkg::tbl_entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### design/nfa_byte_matcher.sv
// Top level of the NFA byte matcher. Uses nfab_pkg, nfab_ifs, nfab_table.
// One item at a time, the next accepted once the result is registered. A load item writes
// the table. Start: the start entry seeds a closure walked through the work stack, one
// more step for each epsilon entry. Byte: one table read per entry, then the same closure
// walk from the matched successors; a stalled result adds its wait.
// Sync active-low reset clears active set and control; table undefined until loaded.
module nfa_byte_matcher #(
  parameter int NUM_STATES = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  nfab_in_if.sink                           in_ch,
  nfab_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [nfab_pkg::IDX_FIELD_W-1:0]  cfg_data
);

  localparam int IDX_W = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(NUM_STATES);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_POP  = 3'd2;
  localparam logic [2:0] ST_POPW = 3'd3;
  localparam logic [2:0] ST_EXP1 = 3'd4;
  localparam logic [2:0] ST_EXP2 = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0]                        state_r, state_nxt;
  logic [NUM_STATES-1:0]             act_r, act_nxt;
  logic [NUM_STATES-1:0]             set_r, set_nxt;
  logic [NUM_STATES-1:0]             acc_r, acc_nxt;
  logic [nfab_pkg::IDX_FIELD_W-1:0]  start_r;
  logic [nfab_pkg::BYTE_W-1:0]       byte_r, byte_nxt;
  logic [CNT_W-1:0]                  scan_cnt_r, scan_cnt_nxt;
  logic                              rd_v_r, rd_v_nxt;
  logic [IDX_W-1:0]                  rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]                  sp_r, sp_nxt;
  nfab_pkg::link_t                   sec_r, sec_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic                              out_matched_r, out_matched_nxt;
  logic                              out_any_r, out_any_nxt;

  // work stack
  logic [IDX_W-1:0]                  stk_mem [NUM_STATES];
  logic [IDX_W-1:0]                  stk_q_r;
  logic [CNT_W-1:0]                  sp_m1;

  // table port
  logic                              tbl_we;
  logic [IDX_W-1:0]                  tbl_wr_addr;
  nfab_pkg::tbl_entry_t              tbl_wr_data;
  logic [IDX_W-1:0]                  tbl_rd_addr;
  nfab_pkg::tbl_entry_t              tbl_rd_data;

  // candidate for the set under construction
  logic                              cand_v;
  logic                              cand_clr;
  logic [nfab_pkg::IDX_FIELD_W-1:0]  cand_idx;
  logic [IDX_W-1:0]                  cand_sel;
  logic                              push_en;

  logic                              in_fire;
  logic                              load_in_range;

  nfab_table #(
    .NUM_STATES (NUM_STATES)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign in_fire           = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.matched    = out_matched_r;
  assign out_ch.any_active = out_any_r;

  // load item write into the table
  assign load_in_range       = (32'(in_ch.entry_index) < NUM_STATES);
  assign tbl_we              = in_fire && (in_ch.req_type == nfab_pkg::REQ_LOAD) &&
                               load_in_range;
  assign tbl_wr_addr         = IDX_W'(in_ch.entry_index);
  assign tbl_wr_data.label   = in_ch.entry_label;
  assign tbl_wr_data.first   = '{present: in_ch.first_present, idx: in_ch.first_next};
  assign tbl_wr_data.second  = '{present: in_ch.second_present, idx: in_ch.second_next};

  assign sp_m1 = sp_r - CNT_W'(1);

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    act_nxt         = act_r;
    set_nxt         = set_r;
    acc_nxt         = acc_r;
    byte_nxt        = byte_r;
    scan_cnt_nxt    = scan_cnt_r;
    rd_v_nxt        = 1'b0;
    rd_idx_nxt      = rd_idx_r;
    sp_nxt          = sp_r;
    sec_nxt         = sec_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_matched_nxt = out_matched_r;
    out_any_nxt     = out_any_r;
    tbl_rd_addr     = scan_cnt_r[IDX_W-1:0];
    cand_v          = 1'b0;
    cand_clr        = 1'b0;
    cand_idx        = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_ch.req_type)
            nfab_pkg::REQ_LOAD: begin
              if (load_in_range) begin
                acc_nxt[tbl_wr_addr] = (in_ch.entry_label == nfab_pkg::LABEL_ACCEPT);
              end
              state_nxt = ST_FIN;
            end
            nfab_pkg::REQ_START: begin
              cand_clr  = 1'b1;
              cand_v    = 1'b1;
              cand_idx  = start_r;
              state_nxt = ST_POP;
            end
            nfab_pkg::REQ_BYTE: begin
              cand_clr     = 1'b1;
              byte_nxt     = in_ch.data_byte;
              scan_cnt_nxt = '0;
              state_nxt    = ST_SCAN;
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end

      // one table read per entry; matching active entries seed the new set
      ST_SCAN: begin
        if (rd_v_r && act_r[rd_idx_r] && tbl_rd_data.first.present &&
            (tbl_rd_data.label == {1'b0, byte_r})) begin
          cand_v   = 1'b1;
          cand_idx = tbl_rd_data.first.idx;
        end
        if (scan_cnt_r != CNT_END) begin
          rd_v_nxt     = 1'b1;
          rd_idx_nxt   = scan_cnt_r[IDX_W-1:0];
          scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
        end else if (!rd_v_r) begin
          state_nxt = ST_POP;
        end
      end

      // take the next entry off the work stack, or finish the closure
      ST_POP: begin
        if (sp_r == '0) begin
          act_nxt   = set_r;
          state_nxt = ST_FIN;
        end else begin
          sp_nxt    = sp_m1;
          state_nxt = ST_POPW;
        end
      end

      ST_POPW: begin
        tbl_rd_addr = stk_q_r;
        state_nxt   = ST_EXP1;
      end

      // epsilon entry: follow first link now, second link next cycle
      ST_EXP1: begin
        if (tbl_rd_data.label == nfab_pkg::LABEL_EPSILON) begin
          cand_v    = tbl_rd_data.first.present;
          cand_idx  = tbl_rd_data.first.idx;
          sec_nxt   = tbl_rd_data.second;
          state_nxt = ST_EXP2;
        end else begin
          state_nxt = ST_POP;
        end
      end

      ST_EXP2: begin
        cand_v    = sec_r.present;
        cand_idx  = sec_r.idx;
        state_nxt = ST_POP;
      end

      // report the active set once the output register is free
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_matched_nxt = |(act_r & acc_r);
          out_any_nxt     = |act_r;
          state_nxt       = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // add a candidate entry once: mark it and push it for expansion
    cand_sel = IDX_W'(cand_idx);
    push_en  = cand_v && (32'(cand_idx) < NUM_STATES) && (cand_clr || !set_r[cand_sel]);
    if (cand_clr) begin
      set_nxt = '0;
    end
    if (push_en) begin
      set_nxt[cand_sel] = 1'b1;
      sp_nxt            = sp_r + CNT_W'(1);
    end
  end

  // work stack memory
  always_ff @(posedge clk) begin
    if (push_en) begin
      stk_mem[sp_r[IDX_W-1:0]] <= cand_sel;
    end
    stk_q_r <= stk_mem[sp_m1[IDX_W-1:0]];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      act_r       <= '0;
      set_r       <= '0;
      acc_r       <= '0;
      start_r     <= '0;
      scan_cnt_r  <= '0;
      rd_v_r      <= 1'b0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      act_r       <= act_nxt;
      set_r       <= set_nxt;
      acc_r       <= acc_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      rd_v_r      <= rd_v_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        start_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    byte_r        <= byte_nxt;
    rd_idx_r      <= rd_idx_nxt;
    sec_r         <= sec_nxt;
    out_matched_r <= out_matched_nxt;
    out_any_r     <= out_any_nxt;
  end

endmodule
